[hdl/stm_pkg.sv]
// Package for the square tone mixer: sizes, constants and the sequencer state type.
package stm_pkg;

    // Block configuration.
    localparam int NUM_CHANNELS   = 4;
    localparam int SAMPLE_RATE_HZ = 44100;

    // Field widths.
    localparam int AMP_W   = 13;
    localparam int CHAN_W  = 2;
    localparam int FREQ_W  = 15;
    localparam int TIME_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int MASK_W  = 4;
    localparam int PER_W   = 16;

    // Derived sizes.
    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DIV_W    = $clog2(SAMPLE_RATE_HZ + 1);
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int ACC_W    = 17 + $clog2(NUM_CHANNELS);
    localparam int FREQ_MAX = SAMPLE_RATE_HZ / 2;
    localparam int PER_MAX  = (1 << PER_W) - 1;

    // Reset value of the amplitude register.
    localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(4000);

    // Input command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_TICK,
        ST_DONE
    } stm_state_t;

endpackage

[hdl/stm_if.sv]
// Handshake interfaces for the input, result and configuration channels.
interface stm_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [stm_pkg::CHAN_W-1:0]        channel;
    logic [stm_pkg::FREQ_W-1:0]        tone_frequency;
    logic [stm_pkg::TIME_W-1:0]        stop_time;
    logic [stm_pkg::TIME_W-1:0]        now_ms;

    modport source (output valid, command, channel, tone_frequency, stop_time, now_ms,
                    input ready);
    modport sink   (input valid, command, channel, tone_frequency, stop_time, now_ms,
                    output ready);
endinterface

interface stm_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [stm_pkg::SAMPLE_W-1:0] sample;
    logic [stm_pkg::MASK_W-1:0]        active_mask;

    modport source (output valid, sample, active_mask, input ready);
    modport sink   (input valid, sample, active_mask, output ready);
endinterface

interface stm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [stm_pkg::AMP_W-1:0]         data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hdl/square_tone_mixer.sv]
// Top level of the four-channel square-wave tone mixer with its shared sequencer.
//
// A start beat is accepted in ST_IDLE and then runs in ST_DIV through a restoring
// divider that works out the channel period one quotient bit per cycle. A tick beat
// is accepted in ST_IDLE; in ST_TICK a single compare-and-accumulate unit then visits
// the channels one after another, and ST_DONE loads the result register; it waits
// there while an earlier result is still held. The block takes no new beat while it
// works on one. Configuration writes are taken at any time, but the amplitude is read
// as each channel is visited, so a write belongs between beats, while nothing is in
// flight.
module square_tone_mixer (
    input  logic          clk,
    input  logic          rst_n,
    stm_in_if.sink        items,
    stm_out_if.source     results,
    stm_cfg_if.sink       cfg
);

    // Sequencer and working registers.
    stm_pkg::stm_state_t                 state_reg, state_next;
    logic [stm_pkg::AMP_W-1:0]           amp_reg;
    logic [stm_pkg::CHAN_W-1:0]          chan_reg;
    logic [stm_pkg::TIME_W-1:0]          time_reg;
    logic [stm_pkg::FREQ_W-1:0]          divisor_reg;
    logic [stm_pkg::FREQ_W-1:0]          rem_reg, rem_next;
    logic [stm_pkg::DIV_W-1:0]           qr_reg, qr_next;
    logic [stm_pkg::DIV_CNT_W-1:0]       div_cnt_reg;
    logic [stm_pkg::CH_IDX_W-1:0]        idx_reg;
    logic signed [stm_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [stm_pkg::MASK_W-1:0]          mask_reg, mask_next;

    // Channel state.
    logic                                active_reg [stm_pkg::NUM_CHANNELS];
    logic [stm_pkg::TIME_W-1:0]          end_reg    [stm_pkg::NUM_CHANNELS];
    logic [stm_pkg::PER_W-1:0]           period_reg [stm_pkg::NUM_CHANNELS];
    logic [stm_pkg::PER_W-1:0]           phase_reg  [stm_pkg::NUM_CHANNELS];

    // Result register.
    logic                                out_valid_reg;
    logic signed [stm_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic [stm_pkg::MASK_W-1:0]          out_mask_reg;

    logic                                in_fire;
    logic                                out_load;
    logic [stm_pkg::FREQ_W-1:0]          freq_clamped;
    logic [stm_pkg::FREQ_W:0]            rem_shift;
    logic                                rem_ge;
    logic [stm_pkg::PER_W-1:0]           period_new;
    logic                                div_last;
    logic                                tick_last;
    logic [stm_pkg::PER_W-1:0]           per_cur;
    logic [stm_pkg::PER_W-1:0]           ph_cur;
    logic [stm_pkg::PER_W:0]             ph_inc;
    logic [stm_pkg::PER_W-1:0]           ph_new;
    logic                                chan_live;
    logic                                first_half;
    logic signed [stm_pkg::ACC_W-1:0]    amp_ext;
    logic signed [stm_pkg::SAMPLE_W-1:0] sample_sat;

    assign items.ready = (state_reg == stm_pkg::ST_IDLE);
    assign in_fire     = items.valid && items.ready;
    assign cfg.ready   = 1'b1;

    assign results.valid       = out_valid_reg;
    assign results.sample      = out_sample_reg;
    assign results.active_mask = out_mask_reg;

    // Clamp the requested frequency to 1..SAMPLE_RATE_HZ/2.
    always_comb
    begin
        if (items.tone_frequency == '0)
        begin
            freq_clamped = stm_pkg::FREQ_W'(1);
        end
        else if (32'(items.tone_frequency) > 32'(stm_pkg::FREQ_MAX))
        begin
            freq_clamped = stm_pkg::FREQ_W'(stm_pkg::FREQ_MAX);
        end
        else
        begin
            freq_clamped = items.tone_frequency;
        end
    end

    // One restoring division step: shift in the next dividend bit and subtract if it fits.
    assign rem_shift = {rem_reg, qr_reg[stm_pkg::DIV_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});
    always_comb
    begin
        rem_next = rem_ge ? stm_pkg::FREQ_W'(rem_shift - {1'b0, divisor_reg})
                          : stm_pkg::FREQ_W'(rem_shift);
        if (stm_pkg::DIV_W > 1)
        begin
            qr_next = {qr_reg[stm_pkg::DIV_W-2:0], rem_ge};
        end
        else
        begin
            qr_next = stm_pkg::DIV_W'(rem_ge);
        end
    end

    // The quotient is final after the last step; saturate it to the period width.
    assign period_new = (32'(qr_next) > 32'(stm_pkg::PER_MAX))
                        ? stm_pkg::PER_W'(stm_pkg::PER_MAX) : stm_pkg::PER_W'(qr_next);
    assign div_last   = (div_cnt_reg == stm_pkg::DIV_CNT_W'(stm_pkg::DIV_W - 1));
    assign tick_last  = (idx_reg == stm_pkg::CH_IDX_W'(stm_pkg::NUM_CHANNELS - 1));

    // Shared channel unit: expiry compare, half-period compare and phase advance.
    always_comb
    begin
        per_cur    = (period_reg[idx_reg] == '0) ? stm_pkg::PER_W'(1) : period_reg[idx_reg];
        ph_cur     = phase_reg[idx_reg];
        chan_live  = active_reg[idx_reg] && (time_reg < end_reg[idx_reg]);
        first_half = (ph_cur < (per_cur >> 1));
        ph_inc     = {1'b0, ph_cur} + (stm_pkg::PER_W+1)'(1);
        ph_new     = (ph_inc >= {1'b0, per_cur}) ? '0 : ph_inc[stm_pkg::PER_W-1:0];
        amp_ext    = stm_pkg::ACC_W'($signed({1'b0, amp_reg}));
        acc_next   = acc_reg;
        mask_next  = mask_reg;
        if (chan_live)
        begin
            acc_next = first_half ? (acc_reg + amp_ext) : (acc_reg - amp_ext);
            for (int b = 0; b < stm_pkg::MASK_W; b++)
            begin
                if ((b < stm_pkg::NUM_CHANNELS) && (idx_reg == stm_pkg::CH_IDX_W'(b)))
                begin
                    mask_next[b] = 1'b1;
                end
            end
        end
    end

    // Saturate the mixed sum to the sample range.
    always_comb
    begin
        if (acc_reg > stm_pkg::ACC_W'(32767))
        begin
            sample_sat = 16'sh7FFF;
        end
        else if (acc_reg < -stm_pkg::ACC_W'(32768))
        begin
            sample_sat = -16'sh8000;
        end
        else
        begin
            sample_sat = stm_pkg::SAMPLE_W'(acc_reg);
        end
    end

    assign out_load = (state_reg == stm_pkg::ST_DONE) && (!out_valid_reg || results.ready);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (items.command == stm_pkg::CMD_START)
                    begin
                        state_next = (32'(items.channel) < 32'(stm_pkg::NUM_CHANNELS))
                                     ? stm_pkg::ST_DIV : stm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = stm_pkg::ST_TICK;
                    end
                end
            end
            stm_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = stm_pkg::ST_IDLE;
                end
            end
            stm_pkg::ST_TICK:
            begin
                if (tick_last)
                begin
                    state_next = stm_pkg::ST_DONE;
                end
            end
            stm_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = stm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stm_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Amplitude register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg <= stm_pkg::AMP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            amp_reg <= cfg.data;
        end
    end

    // Working registers of the divider and the channel walk.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            chan_reg    <= items.channel;
            time_reg    <= (items.command == stm_pkg::CMD_START) ? items.stop_time
                                                                 : items.now_ms;
            divisor_reg <= freq_clamped;
            rem_reg     <= '0;
            qr_reg      <= stm_pkg::DIV_W'(stm_pkg::SAMPLE_RATE_HZ);
            div_cnt_reg <= '0;
            idx_reg     <= '0;
            acc_reg     <= '0;
            mask_reg    <= '0;
        end
        else if (state_reg == stm_pkg::ST_DIV)
        begin
            rem_reg     <= rem_next;
            qr_reg      <= qr_next;
            div_cnt_reg <= div_cnt_reg + stm_pkg::DIV_CNT_W'(1);
        end
        else if (state_reg == stm_pkg::ST_TICK)
        begin
            acc_reg  <= acc_next;
            mask_reg <= mask_next;
            if (!tick_last)
            begin
                idx_reg <= idx_reg + stm_pkg::CH_IDX_W'(1);
            end
        end
    end

    // Channel state: armed at the end of a division, updated as the tick walk visits it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < stm_pkg::NUM_CHANNELS; c++)
            begin
                active_reg[c] <= 1'b0;
                end_reg[c]    <= '0;
                period_reg[c] <= '0;
                phase_reg[c]  <= '0;
            end
        end
        else if ((state_reg == stm_pkg::ST_DIV) && div_last)
        begin
            for (int c = 0; c < stm_pkg::NUM_CHANNELS; c++)
            begin
                if (32'(chan_reg) == 32'(c))
                begin
                    active_reg[c] <= 1'b1;
                    end_reg[c]    <= time_reg;
                    period_reg[c] <= period_new;
                    phase_reg[c]  <= '0;
                end
            end
        end
        else if (state_reg == stm_pkg::ST_TICK)
        begin
            if (chan_live)
            begin
                phase_reg[idx_reg] <= ph_new;
            end
            else
            begin
                active_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // Result register: holds one finished beat until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sample_reg <= sample_sat;
            out_mask_reg   <= mask_reg;
        end
    end

endmodule

[sim/square_tone_mixer_tb.sv]
// Self-checking testbench for the square tone mixer: random and directed beats, predicted samples.
module square_tone_mixer_tb;

    import stm_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 250;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [MASK_W-1:0]          active_mask;
    } mix_result_t;

    // Channel state of the mixer and the samples it still owes.
    class tone_mix_book;
        bit                 chan_on[NUM_CHANNELS];
        logic [TIME_W-1:0]  stop_at[NUM_CHANNELS];
        logic [PER_W-1:0]   period_of[NUM_CHANNELS];
        logic [PER_W-1:0]   phase_of[NUM_CHANNELS];
        logic [AMP_W-1:0]   amplitude;
        mix_result_t        owed_samples[$];
        int                 mismatches;

        function new();
            amplitude  = AMP_RESET;
            mismatches = 0;
            foreach (chan_on[c])
            begin
                chan_on[c]   = 1'b0;
                stop_at[c]   = '0;
                period_of[c] = '0;
                phase_of[c]  = '0;
            end
        endfunction

        // Arm a channel: clamp the frequency, divide it into the sample rate, clear the phase.
        function void arm_channel(logic [CHAN_W-1:0] ch, logic [FREQ_W-1:0] freq,
                                  logic [TIME_W-1:0] stop);
            int unsigned f;
            int unsigned per;
            if (ch >= NUM_CHANNELS)
                return;
            f = 32'(freq);
            if (f < 1)
                f = 1;
            if (f > FREQ_MAX)
                f = FREQ_MAX;
            per = SAMPLE_RATE_HZ / f;
            if (per > PER_MAX)
                per = PER_MAX;
            chan_on[ch]   = 1'b1;
            stop_at[ch]   = stop;
            period_of[ch] = per[PER_W-1:0];
            phase_of[ch]  = '0;
        endfunction

        // Mix one sample at the given time and step every sounding channel.
        function mix_result_t mix_tick(logic [TIME_W-1:0] now);
            mix_result_t r;
            int          sum;
            int          step;
            int unsigned per;
            int unsigned ph;
            sum           = 0;
            step          = int'(amplitude);
            r.active_mask = '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                if (chan_on[c] && now < stop_at[c])
                begin
                    per = (period_of[c] != 0) ? 32'(period_of[c]) : 1;
                    ph  = 32'(phase_of[c]) % per;
                    if (ph < per / 2)
                        sum += step;
                    else
                        sum -= step;
                    ph = ph + 1;
                    if (ph >= per)
                        ph = 0;
                    phase_of[c] = ph[PER_W-1:0];
                    if (c < MASK_W)
                        r.active_mask[c] = 1'b1;
                end
                else
                begin
                    chan_on[c] = 1'b0;
                end
            end
            if (sum > 32767)
                sum = 32767;
            if (sum < -32768)
                sum = -32768;
            r.sample = sum[SAMPLE_W-1:0];
            return r;
        endfunction

        // Note an accepted input beat.
        function void take_item(logic cmd, logic [CHAN_W-1:0] ch, logic [FREQ_W-1:0] freq,
                                logic [TIME_W-1:0] stop, logic [TIME_W-1:0] now);
            if (cmd == CMD_START)
                arm_channel(ch, freq, stop);
            else
                owed_samples.push_back(mix_tick(now));
        endfunction

        // Compare a result beat with the oldest owed sample.
        function void check_mix(logic signed [SAMPLE_W-1:0] sample, logic [MASK_W-1:0] mask);
            mix_result_t want;
            if (owed_samples.size() == 0)
            begin
                $error("result beat with no sample owed: sample=%0d active_mask=%b",
                       sample, mask);
                mismatches++;
                return;
            end
            want = owed_samples.pop_front();
            if (sample !== want.sample)
            begin
                $error("sample: expected %0d, actual %0d", want.sample, sample);
                mismatches++;
            end
            if (mask !== want.active_mask)
            begin
                $error("active_mask: expected %b, actual %b", want.active_mask, mask);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   pace_idle;
    int   ready_hold = 0;
    int   quiet_cycles;

    tone_mix_book book = new();

    stm_in_if  items_ch();
    stm_out_if results_ch();
    stm_cfg_if cfg_ch();

    square_tone_mixer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    // Clock.
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Result side back-pressure in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            results_ch.ready <= 1'b0;
        end
        else if (ready_hold != 0)
        begin
            ready_hold       <= ready_hold - 1;
            results_ch.ready <= 1'b0;
        end
        else if (pace_idle && $urandom_range(0, 9) == 0)
        begin
            ready_hold       <= $urandom_range(0, 14);
            results_ch.ready <= 1'b0;
        end
        else
        begin
            results_ch.ready <= 1'b1;
        end
    end

    // Check every result beat.
    always @(posedge clk)
    begin
        if (rst_n && results_ch.valid && results_ch.ready)
            book.check_mix(results_ch.sample, results_ch.active_mask);
    end

    // Watchdog on cycles without any beat.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $error("no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("** square_tone_mixer: FAILED **");
        $finish;
    end

    // Drive one input beat, with an optional gap in front of it.
    task automatic send_item(input logic cmd, input logic [CHAN_W-1:0] ch,
                             input logic [FREQ_W-1:0] freq, input logic [TIME_W-1:0] stop,
                             input logic [TIME_W-1:0] now);
        int gap;
        if (pace_idle && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid          <= 1'b1;
        items_ch.command        <= cmd;
        items_ch.channel        <= ch;
        items_ch.tone_frequency <= freq;
        items_ch.stop_time      <= stop;
        items_ch.now_ms         <= now;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
        book.take_item(cmd, ch, freq, stop, now);
    endtask

    task automatic start_tone(input logic [CHAN_W-1:0] ch, input logic [FREQ_W-1:0] freq,
                              input logic [TIME_W-1:0] stop);
        send_item(CMD_START, ch, freq, stop, $urandom);
    endtask

    task automatic tick_at(input logic [TIME_W-1:0] now);
        send_item(CMD_TICK, CHAN_W'($urandom_range(0, 3)), FREQ_W'($urandom_range(0, 32767)),
                  $urandom, now);
    endtask

    // Stop sending, let the block go idle, then write the amplitude register.
    task automatic set_amplitude(input logic [AMP_W-1:0] value);
        items_ch.valid <= 1'b0;
        while (book.owed_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid   <= 1'b0;
        book.amplitude  = value;
    endtask

    // Random beats: mostly a running clock with tones armed ahead of it, some noise.
    task automatic run_random(input int count, input bit allow_idle);
        logic [TIME_W-1:0] wall_ms;
        logic              cmd;
        logic [CHAN_W-1:0] ch;
        logic [FREQ_W-1:0] freq;
        logic [TIME_W-1:0] stop;
        logic [TIME_W-1:0] now;
        case ($urandom_range(0, 2))
            0:       wall_ms = '0;
            1:       wall_ms = $urandom;
            default: wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        endcase
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
                pace_idle = allow_idle && ($urandom_range(0, 3) != 0);
            ch   = CHAN_W'($urandom_range(0, 3));
            freq = FREQ_W'($urandom_range(0, 32767));
            stop = $urandom;
            now  = $urandom;
            if ($urandom_range(0, 9) != 0)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    cmd = CMD_START;
                    case ($urandom_range(0, 19))
                        0, 1, 2:    freq = FREQ_W'($urandom_range(1, 999));
                        3, 4, 5:    freq = FREQ_W'($urandom_range(0, 32767));
                        6:          freq = '0;
                        7:          freq = FREQ_W'(FREQ_MAX);
                        8:          freq = FREQ_W'(FREQ_MAX + 1);
                        default:    freq = FREQ_W'($urandom_range(1000, FREQ_MAX));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       stop = wall_ms;
                        1:       stop = '1;
                        2:       stop = $urandom;
                        default: stop = wall_ms + $urandom_range(1, 60);
                    endcase
                end
                else
                begin
                    cmd     = CMD_TICK;
                    wall_ms = wall_ms + $urandom_range(0, 2);
                    now     = wall_ms;
                end
            end
            else
            begin
                cmd = ($urandom_range(0, 1) != 0) ? CMD_START : CMD_TICK;
            end
            send_item(cmd, ch, freq, stop, now);
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n                   = 1'b0;
        pace_idle               = 1'b0;
        items_ch.valid          = 1'b0;
        items_ch.command        = CMD_TICK;
        items_ch.channel        = '0;
        items_ch.tone_frequency = '0;
        items_ch.stop_time      = '0;
        items_ch.now_ms         = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.data             = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: silence after reset, frequency clamps, expiry edges, restarts.
        tick_at(32'd0);
        start_tone(2'd0, 15'd0, 32'hFFFF_FFFF);
        start_tone(2'd1, 15'h7FFF, 32'd100);
        start_tone(2'd2, FREQ_W'(FREQ_MAX), 32'd0);
        start_tone(2'd3, 15'd14700, 32'd5);
        tick_at(32'd0);
        tick_at(32'd1);
        tick_at(32'd4);
        tick_at(32'd5);
        tick_at(32'd99);
        tick_at(32'd100);
        start_tone(2'd2, FREQ_W'(FREQ_MAX + 1), 32'hFFFF_FFFF);
        start_tone(2'd1, 15'd1, 32'h8000_0000);
        tick_at(32'd7);
        tick_at(32'd8);
        start_tone(2'd2, 15'd3000, 32'hFFFF_FFFF);
        tick_at(32'd9);
        tick_at(32'h7FFF_FFFF);
        tick_at(32'hFFFF_FFFE);
        tick_at(32'hFFFF_FFFF);
        start_tone(2'd3, 15'd2, 32'hFFFF_FFFF);
        tick_at(32'h8000_0000);
        tick_at(32'd0);

        // Random phases across amplitude settings, the last one without idling.
        run_random(PHASE_ITEMS, 1'b1);
        set_amplitude(AMP_W'(8191));
        run_random(PHASE_ITEMS, 1'b1);
        set_amplitude('0);
        run_random(PHASE_ITEMS, 1'b1);
        set_amplitude(AMP_W'($urandom_range(1, 8190)));
        run_random(PHASE_ITEMS, 1'b1);
        set_amplitude(AMP_W'(8191));
        pace_idle = 1'b0;
        run_random(PHASE_ITEMS, 1'b0);

        // Drain and report.
        items_ch.valid <= 1'b0;
        while (book.owed_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.mismatches == 0)
            $display("** square_tone_mixer: PASSED **");
        else
            $display("** square_tone_mixer: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hdl/stm_pkg.sv
hdl/stm_if.sv
hdl/square_tone_mixer.sv
sim/square_tone_mixer_tb.sv
